// ===== src/quadratic_root_solver_assert.svh =====
// assertion macros shared by the solver rtl
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define QRS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qrs same-cycle check failed");

// next-cycle implication, checked outside reset
`define QRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qrs next-cycle check failed");

`endif

// ===== src/qrs_pkg.sv =====
package qrs_pkg;
   localparam int COEF_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int OUT_W          = 33;
   localparam int KIND_W         = 2;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [KIND_W-1:0] KIND_REAL    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COMPLEX = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DOUBLE  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;
endpackage

// ===== src/qrs_front.sv =====
module qrs_front import qrs_pkg::*; #(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int ENT_W      = 2 + (2*COEF_WIDTH+2) + (COEF_WIDTH+FRAC_BITS+1) + COEF_WIDTH + 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [COEF_WIDTH-1:0]   in_a,
   input  logic [COEF_WIDTH-1:0]   in_b,
   input  logic [COEF_WIDTH-1:0]   in_c,
   input  q_stat_type              q_stat,
   output logic                    push,
   output logic [ENT_W-1:0]        entry
);
   localparam int CW  = COEF_WIDTH;
   localparam int DW  = 2*CW + 3;
   localparam int MW  = 2*CW + 2;
   localparam int NBW = CW + FRAC_BITS + 1;
   localparam int DNW = CW + 1;

   logic                 valid_ff;
   logic signed [2*CW-1:0] bb_ff, ac_ff;
   logic signed [CW-1:0] a_ff, b_ff;
   logic signed [DW-1:0] d;
   logic [MW-1:0]        mag;
   logic [KIND_W-1:0]    kind;
   logic signed [NBW-1:0] nb;
   logic [DNW-1:0]       den_mag;
   logic                 take;

   assign push     = valid_ff && !q_stat.full;
   assign in_ready = !valid_ff || !q_stat.full;
   assign take     = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (take) begin
         bb_ff <= $signed(in_b) * $signed(in_b);
         ac_ff <= $signed(in_a) * $signed(in_c);
         a_ff  <= $signed(in_a);
         b_ff  <= $signed(in_b);
      end
   end

   always_comb begin
      d = DW'(bb_ff) - (DW'(ac_ff) <<< 2);
      mag = d[DW-1] ? MW'(-d) : MW'(d);
      nb = -(NBW'(b_ff) <<< FRAC_BITS);
      den_mag = a_ff[CW-1] ? DNW'(-(DNW'(a_ff))) << 1 : DNW'(a_ff) << 1;
      if (a_ff == '0) begin
         kind = KIND_INVALID;
      end else if (d[DW-1]) begin
         kind = KIND_COMPLEX;
      end else if (d == '0) begin
         kind = KIND_DOUBLE;
      end else begin
         kind = KIND_REAL;
      end
      entry = {kind, nb, den_mag, a_ff[CW-1], mag};
   end
endmodule

// ===== src/qrs_queue.sv =====
module qrs_queue import qrs_pkg::*; #(
   parameter int W     = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output q_stat_type   q_stat
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [W-1:0]     mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== src/qrs_sqrt.sv =====
module qrs_sqrt import qrs_pkg::*; #(
   parameter int RAD_W  = 66,
   parameter int SIDE_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [RAD_W-1:0]    in_rad,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [RAD_W/2-1:0]  out_root,
   output logic [SIDE_W-1:0]   out_side
);
   localparam int SW  = RAD_W / 2;
   localparam int RMW = SW + 3;

   logic              valid_ff [SW];
   logic [RMW-1:0]    rem_ff   [SW];
   logic [SW-1:0]     root_ff  [SW];
   logic [RAD_W-1:0]  rad_ff   [SW];
   logic [SIDE_W-1:0] side_ff  [SW];

   // one root bit per stage
   for (genvar g = 0; g < SW; g++) begin : g_stage
      logic              v_prev;
      logic [RMW-1:0]    rem_prev;
      logic [SW-1:0]     root_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [RMW-1:0]    cat, trial;
      logic              ge;

      if (g == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign side_prev = in_side;
      end else begin : g_rest
         assign v_prev    = valid_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign root_prev = root_ff[g-1];
         assign rad_prev  = rad_ff[g-1];
         assign side_prev = side_ff[g-1];
      end

      assign cat   = {rem_prev[RMW-3:0], rad_prev[RAD_W-1 -: 2]};
      assign trial = {1'b0, root_prev, 2'b01};
      assign ge    = (cat >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= v_prev;
         end
         if (en) begin
            rem_ff[g]  <= ge ? cat - trial : cat;
            root_ff[g] <= {root_prev[SW-2:0], ge};
            rad_ff[g]  <= {rad_prev[RAD_W-3:0], 2'b00};
            side_ff[g] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[SW-1];
   assign out_root  = root_ff[SW-1];
   assign out_side  = side_ff[SW-1];
endmodule

// ===== src/qrs_div.sv =====
module qrs_div import qrs_pkg::*; #(
   parameter int NUM_W  = 34,
   parameter int DEN_W  = 17,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);
   logic              valid_ff [NUM_W];
   logic [DEN_W-1:0]  rem_ff   [NUM_W];
   logic [NUM_W-1:0]  quo_ff   [NUM_W];
   logic [NUM_W-1:0]  num_ff   [NUM_W];
   logic [DEN_W-1:0]  den_ff   [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];

   // restoring division, one quotient bit per stage
   for (genvar g = 0; g < NUM_W; g++) begin : g_stage
      logic              v_prev;
      logic [DEN_W-1:0]  rem_prev, den_prev;
      logic [NUM_W-1:0]  quo_prev, num_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    cat, diff;
      logic              ge;

      if (g == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign quo_prev  = '0;
         assign num_prev  = in_num;
         assign den_prev  = in_den;
         assign side_prev = in_side;
      end else begin : g_rest
         assign v_prev    = valid_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign quo_prev  = quo_ff[g-1];
         assign num_prev  = num_ff[g-1];
         assign den_prev  = den_ff[g-1];
         assign side_prev = side_ff[g-1];
      end

      assign cat  = {rem_prev, num_prev[NUM_W-1]};
      assign diff = cat - {1'b0, den_prev};
      assign ge   = (cat >= {1'b0, den_prev});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= v_prev;
         end
         if (en) begin
            rem_ff[g]  <= ge ? diff[DEN_W-1:0] : cat[DEN_W-1:0];
            quo_ff[g]  <= {quo_prev[NUM_W-2:0], ge};
            num_ff[g]  <= {num_prev[NUM_W-2:0], 1'b0};
            den_ff[g]  <= den_prev;
            side_ff[g] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = quo_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];
endmodule

// ===== src/quadratic_root_solver.sv =====
// datapath: the discriminant front end register and the queue, then
// (COEF_WIDTH+FRAC_BITS+1) square root stages and the same number plus one
// divider stages, plus the output register
// throughput: one item per cycle unless rsp_tready stalls the back end, set by the fully pipelined root and dividers
// reset: synchronous, active high; clears valid bits, queue pointers and rsp_tvalid
module quadratic_root_solver import qrs_pkg::*; #(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // coef_a, coef_b, coef_c from bit 0 up, zero padded to bytes
   input  logic [((3*COEF_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // root_kind, first_value, second_value from bit 0 up, zero padded to bytes
   output logic [((KIND_W+2*OUT_W+7)/8)*8-1:0] rsp_tdata
);
   `include "quadratic_root_solver_assert.svh"

   localparam int CW     = COEF_WIDTH;
   localparam int MW     = 2*CW + 2;
   localparam int RAD_W  = MW + 2*FRAC_BITS;
   localparam int SW     = RAD_W / 2;
   localparam int NBW    = CW + FRAC_BITS + 1;
   localparam int DNW    = CW + 1;
   localparam int SIDE_W = KIND_W + NBW + DNW + 1;
   localparam int ENT_W  = SIDE_W + MW;
   localparam int NSW    = ((NBW > SW + 1) ? NBW : SW + 1) + 1;
   localparam int NUM_W  = NSW - 1;
   localparam int CMP_W  = (NUM_W > OUT_W) ? NUM_W : OUT_W + 1;
   localparam int RSP_W  = ((KIND_W + 2*OUT_W + 7)/8)*8;

   logic             push, pop, back_en;
   logic [ENT_W-1:0] push_entry, pop_entry;
   q_stat_type       q_stat;

   qrs_front #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS), .ENT_W(ENT_W)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_a(req_tdata[CW-1:0]), .in_b(req_tdata[2*CW-1:CW]), .in_c(req_tdata[3*CW-1:2*CW]),
      .q_stat(q_stat), .push(push), .entry(push_entry)
   );

   qrs_queue #(.W(ENT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_entry),
      .pop(pop), .pop_data(pop_entry), .q_stat(q_stat)
   );

   // back end advances as a whole whenever the output slot can take a beat
   assign back_en = !rsp_tvalid || rsp_tready;
   assign pop     = back_en && !q_stat.empty;

   logic              sq_valid;
   logic [SW-1:0]     sq_root;
   logic [SIDE_W-1:0] sq_side;

   qrs_sqrt #(.RAD_W(RAD_W), .SIDE_W(SIDE_W)) u_sqrt (
      .clock(clock), .reset(reset), .en(back_en),
      .in_valid(pop),
      .in_rad(RAD_W'(pop_entry[MW-1:0]) << (2*FRAC_BITS)),
      .in_side(pop_entry[ENT_W-1:MW]),
      .out_valid(sq_valid), .out_root(sq_root), .out_side(sq_side)
   );

   logic [KIND_W-1:0]     kind;
   logic signed [NBW-1:0] nb;
   logic [DNW-1:0]        den_mag;
   logic                  den_neg;
   logic signed [NSW-1:0] nb_x, s_x, n1, n2;
   logic [NUM_W-1:0]      mag1, mag2;
   logic                  sign1, sign2;

   always_comb begin
      {kind, nb, den_mag, den_neg} = sq_side;
      nb_x = NSW'(nb);
      s_x  = $signed(NSW'(sq_root));
      case (kind)
         KIND_REAL: begin
            n1 = nb_x + s_x;
            n2 = nb_x - s_x;
         end
         KIND_COMPLEX: begin
            n1 = nb_x;
            n2 = s_x;
         end
         KIND_DOUBLE: begin
            n1 = nb_x;
            n2 = nb_x;
         end
         default: begin
            n1 = '0;
            n2 = '0;
         end
      endcase
      mag1  = n1[NSW-1] ? NUM_W'(-n1) : NUM_W'(n1);
      mag2  = n2[NSW-1] ? NUM_W'(-n2) : NUM_W'(n2);
      sign1 = n1[NSW-1] ^ den_neg;
      // imaginary part is reported as a magnitude
      sign2 = (kind == KIND_COMPLEX) ? 1'b0 : (n2[NSW-1] ^ den_neg);
   end

   logic                      dv1, dv2;
   logic [NUM_W-1:0]          q1, q2;
   logic [KIND_W:0]           d1_side;
   logic                      d2_side;

   qrs_div #(.NUM_W(NUM_W), .DEN_W(DNW), .SIDE_W(KIND_W+1)) u_div_first (
      .clock(clock), .reset(reset), .en(back_en),
      .in_valid(sq_valid), .in_num(mag1), .in_den(den_mag), .in_side({kind, sign1}),
      .out_valid(dv1), .out_quo(q1), .out_side(d1_side)
   );

   qrs_div #(.NUM_W(NUM_W), .DEN_W(DNW), .SIDE_W(1)) u_div_second (
      .clock(clock), .reset(reset), .en(back_en),
      .in_valid(sq_valid), .in_num(mag2), .in_den(den_mag), .in_side(sign2),
      .out_valid(dv2), .out_quo(q2), .out_side(d2_side)
   );

   localparam logic [CMP_W-1:0] POS_MAX = CMP_W'((64'd1 << (OUT_W-1)) - 64'd1);
   localparam logic [CMP_W-1:0] NEG_MAX = CMP_W'(64'd1 << (OUT_W-1));

   logic [CMP_W-1:0]  q1_x, q2_x;
   logic [OUT_W-1:0]  v1, v2;
   logic [KIND_W-1:0] out_kind;

   always_comb begin
      q1_x     = CMP_W'(q1);
      q2_x     = CMP_W'(q2);
      out_kind = d1_side[KIND_W:1];
      if (d1_side[0]) begin
         v1 = (q1_x > NEG_MAX) ? OUT_W'(NEG_MAX) : OUT_W'(-q1_x);
      end else begin
         v1 = (q1_x > POS_MAX) ? OUT_W'(POS_MAX) : OUT_W'(q1_x);
      end
      if (d2_side) begin
         v2 = (q2_x > NEG_MAX) ? OUT_W'(NEG_MAX) : OUT_W'(-q2_x);
      end else begin
         v2 = (q2_x > POS_MAX) ? OUT_W'(POS_MAX) : OUT_W'(q2_x);
      end
      if (out_kind == KIND_INVALID) begin
         v1 = '0;
         v2 = '0;
      end
   end

   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (back_en) begin
         rsp_valid_ff <= dv1;
      end
      if (back_en && dv1) begin
         rsp_data_ff <= RSP_W'({v2, v1, out_kind});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `QRS_ASSERT_IMPLY(a_no_push_full, clock, reset, push, !q_stat.full)
   `QRS_ASSERT_IMPLY(a_no_pop_empty, clock, reset, pop, !q_stat.empty)
   `QRS_ASSERT_IMPLY(a_div_aligned, clock, reset, dv1 || dv2, dv1 && dv2)
   `QRS_ASSERT_NEXT(a_invalid_zero, clock, reset,
      back_en && dv1 && (out_kind == KIND_INVALID),
      rsp_data_ff[KIND_W+2*OUT_W-1:KIND_W] == '0)
endmodule

// ===== test/tb_quadratic_root_solver.sv =====
module tb_quadratic_root_solver;
   import qrs_pkg::*;

   localparam int CW = COEF_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int REQ_W = ((3*CW+7)/8)*8;
   localparam int RSP_W = ((KIND_W+2*OUT_W+7)/8)*8;
   localparam int LATENCY = 80;
   localparam int N_RANDOM = 1500;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [OUT_W-1:0]  first;
      logic [OUT_W-1:0]  second;
   } roots_type;

   // expected roots of each accepted coefficient triple
   class roots_scoreboard;
      roots_type pending[$];
      int        errors;

      function automatic longint unsigned root_q(longint unsigned mag);
         longint unsigned r, t;
         logic [127:0] n, p;
         n = {64'd0, mag} << (2*FB);
         r = 0;
         for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            p = {64'd0, t} * {64'd0, t};
            if (p <= n) r = t;
         end
         return r;
      endfunction

      function automatic logic [OUT_W-1:0] sat(longint v);
         longint hi, lo;
         hi = (longint'(1) << (OUT_W-1)) - 1;
         lo = -hi - 1;
         if (v > hi) v = hi;
         if (v < lo) v = lo;
         return v[OUT_W-1:0];
      endfunction

      function void note_coefs(logic signed [CW-1:0] ca, logic signed [CW-1:0] cb,
                               logic signed [CW-1:0] cc);
         roots_type e;
         longint a, b, c, d, den, nb, s, v1, v2;
         a = ca; b = cb; c = cc;
         if (a == 0) begin
            e.kind = KIND_INVALID; e.first = '0; e.second = '0;
         end else begin
            d = b*b - 4*a*c;
            s = longint'(root_q(d < 0 ? -d : d));
            den = 2*a;
            nb = -b * (longint'(1) << FB);
            if (d > 0) begin
               e.kind = KIND_REAL;
               v1 = (nb + s) / den;
               v2 = (nb - s) / den;
            end else if (d < 0) begin
               e.kind = KIND_COMPLEX;
               v1 = nb / den;
               v2 = s / den;
               if (v2 < 0) v2 = -v2;
            end else begin
               e.kind = KIND_DOUBLE;
               v1 = nb / den;
               v2 = v1;
            end
            e.first = sat(v1); e.second = sat(v2);
         end
         pending.push_back(e);
      endfunction

      function void check_roots(logic [RSP_W-1:0] beat);
         roots_type e, g;
         g.kind = beat[KIND_W-1:0];
         g.first = beat[KIND_W +: OUT_W];
         g.second = beat[KIND_W+OUT_W +: OUT_W];
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, beat);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (g.kind !== e.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, e.kind, g.kind);
            errors++;
         end
         if (g.first !== e.first) begin
            $display("%0t: first expected %h actual %h", $time, e.first, g.first);
            errors++;
         end
         if (g.second !== e.second) begin
            $display("%0t: second expected %h actual %h", $time, e.second, g.second);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic long_hold = 0;

   roots_scoreboard sb = new();

   quadratic_root_solver dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_coefs(req_tdata[0 +: CW], req_tdata[CW +: CW], req_tdata[2*CW +: CW]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_roots(rsp_tdata);
   end

   // receiver stall pattern
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if (long_hold) rsp_tready <= 0;
         else if (phase % 400 < 120) rsp_tready <= 1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic send_coefs(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
      req_tvalid <= 1;
      req_tdata <= REQ_W'({c, b, a});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause_sender();
      int gap;
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random();
      logic [CW-1:0] a, b, c, k, r;
      case ($urandom_range(0, 7))
         0: begin a = CW'($urandom); b = CW'($urandom); c = CW'($urandom); end
         1: begin a = CW'($urandom_range(0, 7) - 3); b = CW'($urandom_range(0, 15) - 7);
                   c = CW'($urandom_range(0, 15) - 7); end
         2: begin  // double root: a*(x-r)^2 scaled
               k = CW'($urandom_range(1, 36)); r = CW'($urandom_range(0, 60) - 30);
               if ($urandom_range(0, 1)) k = -k;
               a = k; b = CW'(-2*k*r); c = k*r*r;
            end
         3: begin a = 0; b = CW'($urandom); c = CW'($urandom); end
         default: begin
               a = CW'($urandom); b = CW'($urandom);
               c = CW'($urandom_range(0, 255) - 128);
            end
      endcase
      send_coefs(a, b, c);
   endtask

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [CW-1:0] mx, mn;
      mx = {1'b0, {(CW-1){1'b1}}};
      mn = {1'b1, {(CW-1){1'b0}}};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_coefs(1, -3, 2);
      send_coefs(1, 2, 5);
      send_coefs(1, -2, 1);
      send_coefs(0, 5, 7);
      send_coefs(0, 0, 0);
      send_coefs(mx, mx, mx);
      send_coefs(mn, mn, mn);
      send_coefs(mn, mx, mn);
      send_coefs(mx, mn, mn);
      send_coefs(mn, mn, mx);
      send_coefs(-1, 0, 0);
      send_coefs(1, 0, mn);
      send_coefs(-1, mx, mx);
      send_coefs(2, 0, 1);
      send_coefs(-3, 7, -5);
      send_coefs('1, '1, '1);
      send_coefs(mx, 0, mx);
      send_coefs(1, 1, 0);
      // long receiver hold while the sender keeps offering
      long_hold <= 1;
      fork
         begin
            repeat (300) @(posedge clock);
            long_hold <= 0;
         end
         repeat (120) send_random();
      join
      for (int i = 0; i < N_RANDOM; i++) begin
         send_random();
         if ($urandom_range(0, 9) == 0) pause_sender();
      end
      req_tvalid <= 0;
      wait_drained();
      repeat (LATENCY) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
